FILE: rtl/core/nccl_pkg.sv
`default_nettype none

package nccl_pkg;

    localparam int MAX_DIMS_DEFAULT      = 16;
    localparam int MAX_CENTROIDS_DEFAULT = 16;
    localparam int VALUE_BITS_DEFAULT    = 16;

    localparam int ACC_W          = 37;
    localparam int DIST_W         = 36;
    localparam int CENT_IDX_BITS  = 6;
    localparam int COUNT_W        = 5;
    localparam int CFG_INDEX_BITS = 1;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;

    localparam logic FUNC_CENTROID = 1'b0;
    localparam logic FUNC_SAMPLE   = 1'b1;

    localparam logic [CFG_INDEX_BITS-1:0] REG_DIMS_IN_USE      = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CENTROIDS_IN_USE = 1'b1;

    typedef struct packed {
        logic               func;
        logic [3:0]         centroid_index;
        logic [3:0]         dim_index;
        logic signed [15:0] element_value;
        logic [15:0]        sample_label;
        logic [31:0]        sample_time;
    } item_t;

    typedef struct packed {
        logic [3:0]        nearest_index;
        logic [DIST_W-1:0] nearest_distance;
        logic [15:0]       result_label;
        logic [31:0]       result_time;
    } result_t;

    typedef struct packed {
        logic                     wr_en;
        logic [CENT_IDX_BITS-1:0] wr_centroid;
        logic                     rd_en;
        logic                     mul_en;
        logic                     acc_en;
    } cell_ctrl_t;

    typedef struct packed {
        logic                     valid;
        logic                     found;
        logic [ACC_W-1:0]         best;
        logic [CENT_IDX_BITS-1:0] idx;
    } token_t;

    function automatic logic [COUNT_W-1:0] clamp_count(
        input logic [COUNT_W-1:0] v,
        input logic [6:0]         max_count
    );
        logic [COUNT_W-1:0] r;
        if (v == '0)
        begin
            r = COUNT_W'(1);
        end
        else if ({2'b00, v} > max_count)
        begin
            r = max_count[COUNT_W-1:0];
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/nccl_ram.sv
`default_nettype none

module nccl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                     wdata,
    input  wire logic                                 re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/core/nccl_cell.sv
`default_nettype none

module nccl_cell #(
    parameter int INDEX      = 0,
    parameter int MAX_DIMS   = nccl_pkg::MAX_DIMS_DEFAULT,
    parameter int VALUE_BITS = nccl_pkg::VALUE_BITS_DEFAULT
) (
    input  wire logic                                       clk,
    input  wire logic                                       rst_n,
    input  wire nccl_pkg::cell_ctrl_t                       ctrl,
    input  wire logic [(MAX_DIMS > 1 ? $clog2(MAX_DIMS) : 1)-1:0] dim,
    input  wire logic [VALUE_BITS-1:0]                      value,
    input  wire logic [VALUE_BITS-1:0]                      x,
    input  wire logic [nccl_pkg::COUNT_W-1:0]               count,
    input  wire nccl_pkg::token_t                           tok_in,
    output nccl_pkg::token_t                                tok_out
);

    localparam int ACC_W = nccl_pkg::ACC_W;
    localparam int SQ_W  = 2 * (VALUE_BITS + 1);
    localparam int SUM_W = (SQ_W > ACC_W ? SQ_W : ACC_W) + 1;
    localparam logic [SUM_W-1:0] ACC_MAX = {{(SUM_W - ACC_W){1'b0}}, {ACC_W{1'b1}}};

    logic [VALUE_BITS-1:0]      centroid;
    logic                       we;
    logic                       active;
    logic signed [VALUE_BITS:0] diff;
    logic [VALUE_BITS:0]        mag;
    logic [SQ_W-1:0]            sq_next;
    logic [SQ_W-1:0]            sq_reg;
    logic [SUM_W-1:0]           sum;
    logic [ACC_W-1:0]           acc_next;
    logic [ACC_W-1:0]           acc_reg;
    logic                       take;
    nccl_pkg::token_t           tok_next;
    nccl_pkg::token_t           tok_reg;

    assign we = ctrl.wr_en && (ctrl.wr_centroid == nccl_pkg::CENT_IDX_BITS'(INDEX));

    nccl_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAX_DIMS)
    ) u_row (
        .clk   (clk),
        .we    (we),
        .waddr (dim),
        .wdata (value),
        .re    (ctrl.rd_en),
        .raddr (dim),
        .rdata (centroid)
    );

    assign active = INDEX < int'(count);

    always_comb
    begin
        diff    = $signed({x[VALUE_BITS-1], x}) - $signed({centroid[VALUE_BITS-1], centroid});
        mag     = diff[VALUE_BITS] ? (VALUE_BITS + 1)'(-diff) : diff;
        sq_next = SQ_W'(mag) * SQ_W'(mag);
        sum     = SUM_W'(acc_reg) + SUM_W'(sq_reg);
        acc_next = (sum > ACC_MAX) ? {ACC_W{1'b1}} : sum[ACC_W-1:0];
    end

    always_comb
    begin
        take           = active && (!tok_in.found || (acc_reg < tok_in.best));
        tok_next.valid = tok_in.valid;
        tok_next.found = tok_in.found || active;
        tok_next.best  = take ? acc_reg : tok_in.best;
        tok_next.idx   = take ? nccl_pkg::CENT_IDX_BITS'(INDEX) : tok_in.idx;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            sq_reg <= sq_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
            if (tok_in.valid)
            begin
                acc_reg <= '0;
            end
            else if (ctrl.acc_en && active)
            begin
                acc_reg <= acc_next;
            end
        end
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

FILE: rtl/core/nearest_centroid_classifier_core.sv
// nearest-centroid classifier (k-means assignment step)
// item channel (item_valid/item_ready/item): func 0 writes one centroid
// element, func 1 delivers one sample element, dimensions in ascending order
// result channel (result_valid/result_ready/result): nearest centroid index,
// its squared distance, label and time of the sample's last element
// cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 sets
// dims_in_use, index 1 sets centroids_in_use; always ready, write while idle
// one cell per centroid holds that centroid's row in a small ram and its
// distance accumulator; the search for the minimum walks down the cell row
// centroid element: written on accept; sample element: read, square, add
// last sample element: after the add, a token walks down the cell row, then
// the result goes to the output register; input is ready again in that cycle
// one output register holds a result while the next items are taken; if it
// is still full when a new result is ready, the block waits for result_ready
// reset: registers back to 16, accumulators zero, centroid rows undefined
`default_nettype none

module nearest_centroid_classifier_core #(
    parameter int MAX_DIMS      = nccl_pkg::MAX_DIMS_DEFAULT,
    parameter int MAX_CENTROIDS = nccl_pkg::MAX_CENTROIDS_DEFAULT,
    parameter int VALUE_BITS    = nccl_pkg::VALUE_BITS_DEFAULT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                item_valid,
    output logic                                     item_ready,
    input  wire nccl_pkg::item_t                     item,
    output logic                                     result_valid,
    input  wire logic                                result_ready,
    output nccl_pkg::result_t                        result,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [nccl_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [nccl_pkg::COUNT_W-1:0]        cfg_data
);

    localparam int DIM_W   = MAX_DIMS > 1 ? $clog2(MAX_DIMS) : 1;
    localparam int COUNT_W = nccl_pkg::COUNT_W;
    localparam logic signed [31:0] VHI = (32'sd1 <<< (VALUE_BITS - 1)) - 32'sd1;
    localparam logic signed [31:0] VLO = -VHI - 32'sd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_SCAN,
        ST_PUSH
    } state_t;

    state_t                  state_reg;
    logic [COUNT_W-1:0]      dims_reg;
    logic [COUNT_W-1:0]      cents_reg;
    logic [VALUE_BITS-1:0]   x_reg;
    logic                    last_reg;
    logic [15:0]             label_reg;
    logic [31:0]             time_reg;
    logic [nccl_pkg::ACC_W-1:0]         best_reg;
    logic [nccl_pkg::CENT_IDX_BITS-1:0] idx_reg;
    logic                    inject_reg;
    logic                    result_valid_reg;
    nccl_pkg::result_t       result_reg;

    logic                    accept;
    logic                    in_range;
    logic                    sample_ok;
    logic signed [31:0]      wide;
    logic signed [31:0]      sat;
    logic [VALUE_BITS-1:0]   value;
    logic [7:0]              dim_wide;
    logic [DIM_W-1:0]        dim;
    logic                    out_free;
    nccl_pkg::cell_ctrl_t    ctrl;
    nccl_pkg::token_t        tok [0:MAX_CENTROIDS];

    assign item_ready   = (state_reg == ST_IDLE);
    assign accept       = item_valid && item_ready;
    assign cfg_ready    = 1'b1;
    assign out_free     = !result_valid_reg || result_ready;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        wide = 32'(item.element_value);
        if (wide > VHI)
        begin
            sat = VHI;
        end
        else if (wide < VLO)
        begin
            sat = VLO;
        end
        else
        begin
            sat = wide;
        end
        value    = sat[VALUE_BITS-1:0];
        dim_wide = {4'b0000, item.dim_index};
        dim      = dim_wide[DIM_W-1:0];
        in_range = (int'(item.centroid_index) < MAX_CENTROIDS)
                && (int'(item.dim_index) < MAX_DIMS);
        sample_ok = ({1'b0, item.dim_index} < dims_reg);
    end

    always_comb
    begin
        ctrl.wr_en       = accept && (item.func == nccl_pkg::FUNC_CENTROID) && in_range;
        ctrl.wr_centroid = {2'b00, item.centroid_index};
        ctrl.rd_en       = accept && (item.func == nccl_pkg::FUNC_SAMPLE) && sample_ok;
        ctrl.mul_en      = (state_reg == ST_MUL);
        ctrl.acc_en      = (state_reg == ST_ACC);
    end

    always_comb
    begin
        tok[0].valid = inject_reg;
        tok[0].found = 1'b0;
        tok[0].best  = '0;
        tok[0].idx   = '0;
    end

    for (genvar k = 0; k < MAX_CENTROIDS; k++)
    begin : g_cell
        nccl_cell #(
            .INDEX      (k),
            .MAX_DIMS   (MAX_DIMS),
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (ctrl),
            .dim     (dim),
            .value   (value),
            .x       (x_reg),
            .count   (cents_reg),
            .tok_in  (tok[k]),
            .tok_out (tok[k+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            dims_reg         <= nccl_pkg::clamp_count(nccl_pkg::COUNT_RESET, 7'(MAX_DIMS));
            cents_reg        <= nccl_pkg::clamp_count(nccl_pkg::COUNT_RESET,
                                                      7'(MAX_CENTROIDS));
            inject_reg       <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            inject_reg <= 1'b0;
            if (result_valid_reg && result_ready)
            begin
                result_valid_reg <= 1'b0;
            end

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    nccl_pkg::REG_DIMS_IN_USE:
                        dims_reg <= nccl_pkg::clamp_count(cfg_data, 7'(MAX_DIMS));
                    nccl_pkg::REG_CENTROIDS_IN_USE:
                        cents_reg <= nccl_pkg::clamp_count(cfg_data, 7'(MAX_CENTROIDS));
                    default:
                        ;
                endcase
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (ctrl.rd_en)
                    begin
                        state_reg <= ST_MUL;
                        x_reg     <= value;
                        last_reg  <= ({1'b0, item.dim_index} == (dims_reg - COUNT_W'(1)));
                        label_reg <= item.sample_label;
                        time_reg  <= item.sample_time;
                    end
                end
                ST_MUL:
                begin
                    state_reg <= ST_ACC;
                end
                ST_ACC:
                begin
                    if (last_reg)
                    begin
                        state_reg  <= ST_SCAN;
                        inject_reg <= 1'b1;
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_SCAN:
                begin
                    if (tok[MAX_CENTROIDS].valid)
                    begin
                        best_reg  <= tok[MAX_CENTROIDS].best;
                        idx_reg   <= tok[MAX_CENTROIDS].idx;
                        state_reg <= ST_PUSH;
                    end
                end
                ST_PUSH:
                begin
                    if (out_free)
                    begin
                        result_valid_reg             <= 1'b1;
                        result_reg.nearest_index     <= idx_reg[3:0];
                        result_reg.nearest_distance  <= best_reg[nccl_pkg::ACC_W-1]
                            ? {nccl_pkg::DIST_W{1'b1}} : best_reg[nccl_pkg::DIST_W-1:0];
                        result_reg.result_label      <= label_reg;
                        result_reg.result_time       <= time_reg;
                        state_reg                    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: tb/sv/nearest_centroid_classifier_core_test.sv
`timescale 1ns / 100ps

module nearest_centroid_classifier_core_test;

    localparam int                 NUM_DIMS      = nccl_pkg::MAX_DIMS_DEFAULT;
    localparam int                 NUM_CENTROIDS = nccl_pkg::MAX_CENTROIDS_DEFAULT;
    localparam int                 SETTLE_CYCLES = nccl_pkg::MAX_CENTROIDS_DEFAULT + 8;
    localparam longint             ACC_LIMIT     = 64'h0000_001F_FFFF_FFFF;
    localparam longint             DIST_LIMIT    = 64'h0000_000F_FFFF_FFFF;
    localparam logic signed [15:0] VALUE_MIN     = 16'sh8000;
    localparam logic signed [15:0] VALUE_MAX     = 16'sh7FFF;

    logic                                clk          = 1'b0;
    logic                                rst_n        = 1'b0;
    logic                                item_valid   = 1'b0;
    logic                                item_ready;
    nccl_pkg::item_t                     item         = '0;
    logic                                result_valid;
    logic                                result_ready = 1'b0;
    nccl_pkg::result_t                   result;
    logic                                cfg_valid    = 1'b0;
    logic                                cfg_ready;
    logic [nccl_pkg::CFG_INDEX_BITS-1:0] cfg_index    = '0;
    logic [nccl_pkg::COUNT_W-1:0]        cfg_data     = '0;

    nccl_pkg::item_t   item_backlog[$];
    nccl_pkg::result_t awaited_assignments[$];
    nccl_pkg::result_t want_result;

    logic signed [15:0]           centroid_rows [NUM_CENTROIDS][NUM_DIMS];
    logic [36:0]                  dist_acc [NUM_CENTROIDS];
    bit                           entry_set [NUM_CENTROIDS][NUM_DIMS];
    logic [nccl_pkg::COUNT_W-1:0] dims_now  = nccl_pkg::COUNT_RESET;
    logic [nccl_pkg::COUNT_W-1:0] cents_now = nccl_pkg::COUNT_RESET;

    int unsigned sender_idle_pct   = 32;
    int unsigned receiver_idle_pct = 86;
    int          items_queued      = 0;
    int          items_taken       = 0;
    int          results_seen      = 0;
    int          mismatch_count    = 0;

    nearest_centroid_classifier_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic logic [nccl_pkg::COUNT_W-1:0] limit_count(
        input logic [nccl_pkg::COUNT_W-1:0] raw,
        input int top
    );
        if (raw == '0)
            return nccl_pkg::COUNT_W'(1);
        if (int'(raw) > top)
            return nccl_pkg::COUNT_W'(top);
        return raw;
    endfunction

    function automatic void compute_assignment(input nccl_pkg::item_t it);
        longint            diff;
        longint            total;
        longint            best;
        int                best_at;
        nccl_pkg::result_t r;
        if (it.func == nccl_pkg::FUNC_CENTROID)
        begin
            centroid_rows[it.centroid_index][it.dim_index] = it.element_value;
            return;
        end
        if (it.dim_index >= dims_now)
            return;
        for (int k = 0; k < cents_now; k++)
        begin
            diff  = longint'($signed(it.element_value))
                  - longint'(centroid_rows[k][it.dim_index]);
            total = longint'(dist_acc[k]) + diff * diff;
            dist_acc[k] = (total > ACC_LIMIT) ? 37'(ACC_LIMIT) : 37'(total);
        end
        if (it.dim_index != dims_now - 1)
            return;
        best    = longint'(dist_acc[0]);
        best_at = 0;
        for (int k = 1; k < cents_now; k++)
        begin
            if (longint'(dist_acc[k]) < best)
            begin
                best    = longint'(dist_acc[k]);
                best_at = k;
            end
        end
        r.nearest_index    = 4'(best_at);
        r.nearest_distance = (best > DIST_LIMIT) ? nccl_pkg::DIST_W'(DIST_LIMIT)
                                                 : nccl_pkg::DIST_W'(best);
        r.result_label     = it.sample_label;
        r.result_time      = it.sample_time;
        awaited_assignments.push_back(r);
        for (int k = 0; k < NUM_CENTROIDS; k++)
            dist_acc[k] = '0;
    endfunction

    function automatic logic signed [15:0] pick_value(input bit narrow);
        int roll;
        roll = $urandom_range(0, 9);
        if (narrow)
            return 16'(int'($urandom_range(0, 2)) - 1);
        if (roll == 0)
            return VALUE_MIN;
        if (roll == 1)
            return VALUE_MAX;
        return 16'($urandom);
    endfunction

    task automatic queue_item(input logic f, input int c, input int d,
                              input logic signed [15:0] v, input logic [15:0] lbl,
                              input logic [31:0] stamp);
        nccl_pkg::item_t it;
        it.func           = f;
        it.centroid_index = 4'(c);
        it.dim_index      = 4'(d);
        it.element_value  = v;
        it.sample_label   = lbl;
        it.sample_time    = stamp;
        item_backlog.push_back(it);
        items_queued++;
        if (f == nccl_pkg::FUNC_CENTROID)
            entry_set[c][d] = 1'b1;
    endtask

    task automatic queue_sample(input int d, input logic signed [15:0] v);
        queue_item(nccl_pkg::FUNC_SAMPLE, $urandom_range(0, 15), d, v, 16'($urandom),
                   $urandom);
    endtask

    task automatic write_register(input logic [nccl_pkg::CFG_INDEX_BITS-1:0] idx,
                                  input logic [nccl_pkg::COUNT_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == nccl_pkg::REG_DIMS_IN_USE)
            dims_now = limit_count(data, NUM_DIMS);
        else
            cents_now = limit_count(data, NUM_CENTROIDS);
    endtask

    // every item taken and every result back, then room for a trailing element
    task automatic settle();
        while (items_taken != items_queued || awaited_assignments.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input logic [nccl_pkg::COUNT_W-1:0] dims_raw,
                             input logic [nccl_pkg::COUNT_W-1:0] cents_raw,
                             input bit narrow, input bit rewrite, input int budget);
        int counted;
        int roll;
        int n;
        counted = 0;
        settle();
        write_register(nccl_pkg::REG_DIMS_IN_USE, dims_raw);
        write_register(nccl_pkg::REG_CENTROIDS_IN_USE, cents_raw);
        for (int c = 0; c < cents_now; c++)
        begin
            for (int d = 0; d < dims_now; d++)
            begin
                if (rewrite || !entry_set[c][d])
                begin
                    queue_item(nccl_pkg::FUNC_CENTROID, c, d, pick_value(narrow),
                               16'($urandom), $urandom);
                    counted++;
                end
            end
        end
        while (counted < budget)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 65)
            begin
                for (int d = 0; d < dims_now; d++)
                    queue_sample(d, pick_value(narrow));
                counted += dims_now;
            end
            else if (roll < 75)
            begin
                n = $urandom_range(1, 4);
                repeat (n)
                    queue_item(nccl_pkg::FUNC_CENTROID, $urandom_range(0, 15),
                               $urandom_range(0, 15), pick_value(narrow),
                               16'($urandom), $urandom);
                counted += n;
            end
            else if (roll < 83)
            begin
                if (dims_now < NUM_DIMS)
                    queue_sample($urandom_range(dims_now, 15), pick_value(narrow));
            end
            else if (roll < 92)
            begin
                if (dims_now > 1)
                begin
                    n = $urandom_range(1, dims_now - 1);
                    for (int d = 0; d < n; d++)
                        queue_sample(d, pick_value(narrow));
                    counted += n;
                end
            end
            else
            begin
                // scrambled and repeated dimensions ahead of the last one
                n = $urandom_range(0, 4);
                repeat (n)
                    queue_sample($urandom_range(0, dims_now - 1), pick_value(narrow));
                queue_sample(dims_now - 1, pick_value(narrow));
                counted += n + 1;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item       <= '0;
        end
        else
        begin
            if (item_valid && item_ready)
            begin
                compute_assignment(item);
                items_taken++;
            end
            if (!item_valid || item_ready)
            begin
                if (item_backlog.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct)
                begin
                    item_valid <= 1'b1;
                    item       <= item_backlog.pop_front();
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                results_seen++;
                if (awaited_assignments.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("unexpected result: index %0d distance %0d label %h time %h",
                                 result.nearest_index, result.nearest_distance,
                                 result.result_label, result.result_time);
                    mismatch_count++;
                end
                else
                begin
                    want_result = awaited_assignments.pop_front();
                    if (result.nearest_index !== want_result.nearest_index
                        || result.nearest_distance !== want_result.nearest_distance
                        || result.result_label !== want_result.result_label
                        || result.result_time !== want_result.result_time)
                    begin
                        if (mismatch_count < 10)
                        begin
                            $display("mismatch: expected index %0d distance %0d label %h time %h",
                                     want_result.nearest_index, want_result.nearest_distance,
                                     want_result.result_label, want_result.result_time);
                            $display("          actual   index %0d distance %0d label %h time %h",
                                     result.nearest_index, result.nearest_distance,
                                     result.result_label, result.result_time);
                        end
                        mismatch_count++;
                    end
                end
            end
            result_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    initial
    begin
        for (int c = 0; c < NUM_CENTROIDS; c++)
        begin
            dist_acc[c] = '0;
            for (int d = 0; d < NUM_DIMS; d++)
                centroid_rows[c][d] = '0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, exact hit, tie, ignored and out-of-order dimensions
        write_register(nccl_pkg::REG_DIMS_IN_USE, 5'd2);
        write_register(nccl_pkg::REG_CENTROIDS_IN_USE, 5'd3);
        queue_item(nccl_pkg::FUNC_CENTROID, 0, 0, VALUE_MIN, 16'h0000, 32'h0000_0000);
        queue_item(nccl_pkg::FUNC_CENTROID, 0, 1, VALUE_MAX, 16'hFFFF, 32'hFFFF_FFFF);
        queue_item(nccl_pkg::FUNC_CENTROID, 1, 0, VALUE_MAX, 16'h0000, 32'h0000_0000);
        queue_item(nccl_pkg::FUNC_CENTROID, 1, 1, VALUE_MIN, 16'hFFFF, 32'hFFFF_FFFF);
        queue_item(nccl_pkg::FUNC_CENTROID, 2, 0, VALUE_MIN, 16'h0000, 32'h0000_0000);
        queue_item(nccl_pkg::FUNC_CENTROID, 2, 1, VALUE_MAX, 16'hFFFF, 32'hFFFF_FFFF);
        queue_item(nccl_pkg::FUNC_SAMPLE, 15, 0, VALUE_MAX, 16'h0000, 32'h0000_0000);
        queue_item(nccl_pkg::FUNC_SAMPLE, 15, 1, VALUE_MIN, 16'hFFFF, 32'hFFFF_FFFF);
        queue_item(nccl_pkg::FUNC_SAMPLE, 0, 0, VALUE_MIN, 16'hFFFF, 32'hFFFF_FFFF);
        queue_item(nccl_pkg::FUNC_SAMPLE, 0, 1, VALUE_MAX, 16'h0000, 32'h0000_0000);
        queue_item(nccl_pkg::FUNC_SAMPLE, 9, 15, VALUE_MAX, 16'hA5A5, 32'h5A5A_5A5A);
        queue_sample(1, VALUE_MIN);
        queue_sample(0, VALUE_MAX);
        queue_sample(0, VALUE_MIN);
        queue_sample(1, 16'sh0000);

        run_phase(5'd0, 5'd31, 1'b0, 1'b0, 150);
        run_phase(5'd3, 5'd5, 1'b0, 1'b0, 200);
        sender_idle_pct   = 86;
        receiver_idle_pct = 32;
        run_phase(5'd17, 5'd16, 1'b0, 1'b0, 320);
        run_phase(5'd2, 5'd1, 1'b1, 1'b1, 150);
        // distance beyond the output width, then accumulator saturation
        queue_item(nccl_pkg::FUNC_CENTROID, 0, 0, VALUE_MIN, 16'($urandom), $urandom);
        queue_item(nccl_pkg::FUNC_CENTROID, 0, 1, VALUE_MIN, 16'($urandom), $urandom);
        repeat (17) queue_sample(0, VALUE_MAX);
        queue_sample(1, VALUE_MAX);
        repeat (40) queue_sample(0, VALUE_MAX);
        queue_sample(1, VALUE_MAX);
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        run_phase(5'd4, 5'd16, 1'b1, 1'b1, 250);
        run_phase(5'd1, 5'd0, 1'b0, 1'b0, 100);
        settle();

        $display("stimulus: %0d items over seven register settings, sizes 1 to 16",
                 items_taken);
        $display("checked %0d nearest-centroid results, %0d mismatches",
                 results_seen, mismatch_count);
        if (mismatch_count == 0 && awaited_assignments.size() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial
    begin
        #7_200_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: nearest_centroid_classifier_core.f
rtl/core/nccl_pkg.sv
rtl/core/nccl_ram.sv
rtl/core/nccl_cell.sv
rtl/core/nearest_centroid_classifier_core.sv
tb/sv/nearest_centroid_classifier_core_test.sv
